// ===== src/sorted_site_overlap_sweep_core_macros.svh =====
// Assertion macros shared by the sweep core.
`ifndef SORTED_SITE_OVERLAP_SWEEP_CORE_MACROS_SVH
`define SORTED_SITE_OVERLAP_SWEEP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sso_pkg.sv =====
`timescale 1ns / 1ps

package sso_pkg;

    localparam int TABLE_DEPTH_DEF      = 4096;
    localparam int MAX_HITS_EMITTED_DEF = 63;

    localparam int CHROM_W  = 16;
    localparam int POS_W    = 31;
    localparam int SAMPLE_W = 16;
    localparam int VIDX_W   = 12;
    localparam int COUNT_W  = 13;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 48;

    localparam int IN_CHROM_LSB  = 0;
    localparam int IN_START_LSB  = IN_CHROM_LSB + CHROM_W;
    localparam int IN_END_LSB    = IN_START_LSB + POS_W;
    localparam int IN_SITE_LSB   = IN_END_LSB + POS_W;
    localparam int IN_SAMPLE_LSB = IN_SITE_LSB + POS_W;
    localparam int IN_USED_W     = IN_SAMPLE_LSB + SAMPLE_W;

    localparam int OUT_USED_W = VIDX_W + SAMPLE_W + COUNT_W + 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_READ    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_ACK    = 2'd0,
        KIND_SITE_HIT    = 2'd1,
        KIND_READ_DONE   = 2'd2,
        KIND_RESTART_ACK = 2'd3
    } kind_t;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   span_start;
        logic [POS_W-1:0]   span_end;
        logic [POS_W-1:0]   position;
    } site_entry_t;

    typedef struct packed {
        logic stop;
        logic behind;
        logic hit;
    } cmp_res_t;

endpackage

// ===== src/sso_site_mem.sv =====
`timescale 1ns / 1ps

module sso_site_mem
    import sso_pkg::*;
#(
    parameter int DEPTH  = TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  site_entry_t       wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output site_entry_t       rd_data
);

    site_entry_t mem [DEPTH];
    site_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/sso_cmp_unit.sv =====
`timescale 1ns / 1ps

module sso_cmp_unit
    import sso_pkg::*;
(
    input  logic [CHROM_W-1:0] read_chrom,
    input  logic [POS_W-1:0]   read_start,
    input  logic [POS_W-1:0]   read_end,
    input  site_entry_t        site,
    output cmp_res_t           res
);

    logic chrom_lt;
    logic chrom_eq;
    logic chrom_gt;

    always_comb
    begin
        chrom_lt   = read_chrom < site.chrom;
        chrom_eq   = read_chrom == site.chrom;
        chrom_gt   = read_chrom > site.chrom;
        res.stop   = chrom_lt || (chrom_eq && (read_end < site.span_start));
        res.behind = chrom_gt || (read_start > site.span_end);
        res.hit    = (read_start <= site.position) && (site.position <= read_end);
    end

endmodule

// ===== src/sorted_site_overlap_sweep_core.sv =====
`timescale 1ns / 1ps

// Sorted site overlap sweep. Sites are loaded in (chromosome, start) order into a
// single-port-read site table; the block itself does not enforce it. Each read is then
// checked against the table one entry per clock, save while a hit waits on the output,
// by a shared compare unit, starting at a kept first-live pointer that sorted reads push
// forward. A load or restart result enters the output register from ST_LOAD or ST_ACK
// once that register is free, and the next input transfer can be taken once it is there.
// A read scans until it stops, then presents its done result from ST_DONE once the
// output register is free. A new input transfer is taken only between items, while the
// last result may still be waiting on the output. Hit transfers are followed by one
// read-done transfer with the count, and hits beyond the emission cap are counted and
// flagged rather than sent. The table needs no clearing after reset.
module sorted_site_overlap_sweep_core
    import sso_pkg::*;
#(
    parameter int TABLE_DEPTH      = TABLE_DEPTH_DEF,
    parameter int MAX_HITS_EMITTED = MAX_HITS_EMITTED_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // chrom, start_pos, end_pos, site_pos, sample_index, zero fill.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // op.
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // variant_index, hit_sample, hit_count, hit_overflow, table_full, zero fill.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // kind.
    output logic [KIND_W-1:0]      m_tuser,
    output logic                   m_tlast
);

    `include "sorted_site_overlap_sweep_core_macros.svh"

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ACK,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CHROM_W-1:0]  chrom_reg, chrom_next;
    logic [POS_W-1:0]    beg_reg, beg_next;
    logic [POS_W-1:0]    fin_reg, fin_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [CNT_W-1:0]    site_count_reg, site_count_next;
    logic [CNT_W-1:0]    first_live_reg, first_live_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [COUNT_W-1:0]  hits_reg, hits_next;
    logic                ovf_reg, ovf_next;
    logic                head_reg, head_next;

    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [VIDX_W-1:0]   out_vidx_reg, out_vidx_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                out_ovf_reg, out_ovf_next;
    logic                out_full_reg, out_full_next;
    logic                out_last_reg, out_last_next;

    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                mem_wr_en;
    site_entry_t         mem_wr_data;
    site_entry_t         mem_rd_data;
    cmp_res_t            cmp_res;
    logic [CNT_W-1:0]    live_start;
    logic                table_is_full;

    assign s_tready  = state_reg == ST_IDLE;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign live_start    = (first_live_reg > site_count_reg) ? site_count_reg : first_live_reg;
    assign table_is_full = site_count_reg >= CNT_W'(TABLE_DEPTH);

    assign mem_wr_data.chrom      = chrom_reg;
    assign mem_wr_data.span_start = beg_reg;
    assign mem_wr_data.span_end   = fin_reg;
    assign mem_wr_data.position   = pos_reg;

    sso_site_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_site_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (site_count_reg[IDX_W-1:0]),
        .wr_data (mem_wr_data),
        .rd_addr (idx_next[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    sso_cmp_unit u_cmp_unit (
        .read_chrom (chrom_reg),
        .read_start (beg_reg),
        .read_end   (fin_reg),
        .site       (mem_rd_data),
        .res        (cmp_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        chrom_next      = chrom_reg;
        beg_next        = beg_reg;
        fin_next        = fin_reg;
        pos_next        = pos_reg;
        sample_next     = sample_reg;
        site_count_next = site_count_reg;
        first_live_next = first_live_reg;
        idx_next        = idx_reg;
        hits_next       = hits_reg;
        ovf_next        = ovf_reg;
        head_next       = head_reg;
        mem_wr_en       = 1'b0;
        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_vidx_next   = out_vidx_reg;
        out_sample_next = out_sample_reg;
        out_count_next  = out_count_reg;
        out_ovf_next    = out_ovf_reg;
        out_full_next   = out_full_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    chrom_next  = s_tdata[IN_CHROM_LSB +: CHROM_W];
                    beg_next    = s_tdata[IN_START_LSB +: POS_W];
                    fin_next    = s_tdata[IN_END_LSB +: POS_W];
                    pos_next    = s_tdata[IN_SITE_LSB +: POS_W];
                    sample_next = s_tdata[IN_SAMPLE_LSB +: SAMPLE_W];
                    unique case (s_tuser)
                        OP_LOAD:
                        begin
                            state_next = ST_LOAD;
                        end
                        OP_READ:
                        begin
                            first_live_next = live_start;
                            idx_next        = live_start;
                            hits_next       = '0;
                            ovf_next        = 1'b0;
                            head_next       = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        OP_RESTART:
                        begin
                            first_live_next = '0;
                            state_next      = ST_ACK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = KIND_LOAD_ACK;
                    out_sample_next = '0;
                    out_count_next  = '0;
                    out_ovf_next    = 1'b0;
                    out_last_next   = 1'b1;
                    if (table_is_full)
                    begin
                        out_vidx_next = '0;
                        out_full_next = 1'b1;
                    end
                    else
                    begin
                        mem_wr_en       = 1'b1;
                        out_vidx_next   = VIDX_W'(site_count_reg);
                        out_full_next   = 1'b0;
                        site_count_next = site_count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_ACK:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = KIND_RESTART_ACK;
                    out_vidx_next   = '0;
                    out_sample_next = '0;
                    out_count_next  = '0;
                    out_ovf_next    = 1'b0;
                    out_full_next   = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                priority if (idx_reg >= site_count_reg || cmp_res.stop)
                begin
                    state_next = ST_DONE;
                end
                else if (cmp_res.behind)
                begin
                    if (head_reg)
                    begin
                        first_live_next = idx_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else if (!cmp_res.hit)
                begin
                    head_next = 1'b0;
                    idx_next  = idx_reg + 1'b1;
                end
                else if (hits_reg >= COUNT_W'(MAX_HITS_EMITTED))
                begin
                    head_next = 1'b0;
                    ovf_next  = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    if (hits_reg != COUNT_SAT)
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                end
                else if (out_free)
                begin
                    head_next       = 1'b0;
                    out_load        = 1'b1;
                    out_kind_next   = KIND_SITE_HIT;
                    out_vidx_next   = VIDX_W'(idx_reg);
                    out_sample_next = sample_reg;
                    out_count_next  = '0;
                    out_ovf_next    = 1'b0;
                    out_full_next   = 1'b0;
                    out_last_next   = 1'b0;
                    hits_next       = hits_reg + 1'b1;
                    idx_next        = idx_reg + 1'b1;
                end
                else
                begin
                    head_next = 1'b0;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = KIND_READ_DONE;
                    out_vidx_next   = '0;
                    out_sample_next = sample_reg;
                    out_count_next  = hits_reg;
                    out_ovf_next    = ovf_reg;
                    out_full_next   = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chrom_reg      <= '0;
            beg_reg        <= '0;
            fin_reg        <= '0;
            pos_reg        <= '0;
            sample_reg     <= '0;
            site_count_reg <= '0;
            first_live_reg <= '0;
            idx_reg        <= '0;
            hits_reg       <= '0;
            ovf_reg        <= 1'b0;
            head_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_LOAD_ACK;
            out_vidx_reg   <= '0;
            out_sample_reg <= '0;
            out_count_reg  <= '0;
            out_ovf_reg    <= 1'b0;
            out_full_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chrom_reg      <= chrom_next;
            beg_reg        <= beg_next;
            fin_reg        <= fin_next;
            pos_reg        <= pos_next;
            sample_reg     <= sample_next;
            site_count_reg <= site_count_next;
            first_live_reg <= first_live_next;
            idx_reg        <= idx_next;
            hits_reg       <= hits_next;
            ovf_reg        <= ovf_next;
            head_reg       <= head_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_vidx_reg   <= out_vidx_next;
            out_sample_reg <= out_sample_next;
            out_count_reg  <= out_count_next;
            out_ovf_reg    <= out_ovf_next;
            out_full_reg   <= out_full_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_full_reg, out_ovf_reg,
                       out_count_reg, out_sample_reg, out_vidx_reg};

    `SSO_ASSERT_NOW(a_live_within_table, clk, rst_n, 1'b1,
        first_live_reg <= site_count_reg, "first-live pointer beyond loaded sites")

    `SSO_ASSERT_NOW(a_scan_from_live, clk, rst_n, state_reg == ST_SCAN,
        idx_reg >= first_live_reg, "scan index behind first-live pointer")

    `SSO_ASSERT_NEXT(a_count_monotonic, clk, rst_n, 1'b1,
        site_count_reg >= $past(site_count_reg), "site count decreased")

endmodule

// ===== sim/tb_sorted_site_overlap_sweep_core.sv =====
`timescale 1ns / 1ps

module tb_sorted_site_overlap_sweep_core;
    import sso_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned RANDOM_ITEMS   = 180;
    localparam logic [POS_W-1:0] POS_MAX   = '1;
    localparam logic [CHROM_W-1:0] CHROM_MAX = '1;
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [VIDX_W-1:0]   vidx;
        logic [SAMPLE_W-1:0] sample;
        logic [COUNT_W-1:0]  count;
        logic                ovf;
        logic                full;
        logic                last;
    } sweep_result_t;

    class overlap_scoreboard;
        site_entry_t   sites_mem [TABLE_DEPTH_DEF];
        int unsigned   loaded;
        int unsigned   live_head;
        int unsigned   mismatches;
        sweep_result_t pending_outputs [$];

        function new();
            loaded = 0;
            live_head = 0;
            mismatches = 0;
        endfunction

        function void push_result(logic [KIND_W-1:0] kind, logic [VIDX_W-1:0] vidx,
                                  logic [SAMPLE_W-1:0] sample, logic [COUNT_W-1:0] count,
                                  logic ovf, logic full, logic last);
            sweep_result_t r;
            r.kind = kind;
            r.vidx = vidx;
            r.sample = sample;
            r.count = count;
            r.ovf = ovf;
            r.full = full;
            r.last = last;
            pending_outputs.insert(pending_outputs.size(), r);
        endfunction

        function void take_item(logic [OP_W-1:0] op, site_entry_t item,
                                logic [SAMPLE_W-1:0] sample);
            int unsigned hits;
            int unsigned i;
            logic        ovf;
            logic        head;
            hits = 0;
            ovf = 1'b0;
            head = 1'b1;
            if (op == OP_LOAD)
            begin
                if (loaded >= TABLE_DEPTH_DEF)
                begin
                    push_result(KIND_LOAD_ACK, '0, '0, '0, 1'b0, 1'b1, 1'b1);
                end
                else
                begin
                    sites_mem[loaded] = item;
                    push_result(KIND_LOAD_ACK, VIDX_W'(loaded), '0, '0, 1'b0, 1'b0, 1'b1);
                    loaded++;
                end
            end
            else if (op == OP_RESTART)
            begin
                live_head = 0;
                push_result(KIND_RESTART_ACK, '0, '0, '0, 1'b0, 1'b0, 1'b1);
            end
            else if (op == OP_READ)
            begin
                for (i = live_head; i < loaded; i++)
                begin
                    if (item.chrom < sites_mem[i].chrom)
                        break;
                    if (item.chrom == sites_mem[i].chrom &&
                        item.span_end < sites_mem[i].span_start)
                        break;
                    if (item.chrom > sites_mem[i].chrom ||
                        item.span_start > sites_mem[i].span_end)
                    begin
                        if (head)
                            live_head = i + 1;
                        continue;
                    end
                    head = 1'b0;
                    if (item.span_start <= sites_mem[i].position &&
                        sites_mem[i].position <= item.span_end)
                    begin
                        if (hits < MAX_HITS_EMITTED_DEF)
                            push_result(KIND_SITE_HIT, VIDX_W'(i), sample, '0, 1'b0, 1'b0, 1'b0);
                        else
                            ovf = 1'b1;
                        if (hits < COUNT_SAT)
                            hits++;
                    end
                end
                push_result(KIND_READ_DONE, '0, sample, COUNT_W'(hits), ovf, 1'b0, 1'b1);
            end
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_output(logic [KIND_W-1:0] kind, logic [VIDX_W-1:0] vidx,
                                   logic [SAMPLE_W-1:0] sample, logic [COUNT_W-1:0] count,
                                   logic ovf, logic full, logic last);
            sweep_result_t want;
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected result transfer: kind %0d, variant_index %0d", kind, vidx);
                mismatches++;
                return;
            end
            want = pending_outputs.pop_front();
            compare("kind", 16'(want.kind), 16'(kind));
            compare("variant_index", 16'(want.vidx), 16'(vidx));
            compare("hit_sample", want.sample, sample);
            compare("hit_count", 16'(want.count), 16'(count));
            compare("hit_overflow", 16'(want.ovf), 16'(ovf));
            compare("table_full", 16'(want.full), 16'(full));
            compare("last", 16'(want.last), 16'(last));
        endfunction

        function int unsigned pending();
            return pending_outputs.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;

    logic                   burst_mode = 1'b0;
    int unsigned            rx_hold = 0;
    int unsigned            quiet_cycles = 0;

    overlap_scoreboard sb = new();

    sorted_site_overlap_sweep_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned draw_gap();
        if (burst_mode)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // Result side: check every transfer, then hold off ready for a random stretch.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            int unsigned gap;
            sb.check_output(m_tuser, m_tdata[VIDX_W-1:0], m_tdata[VIDX_W +: SAMPLE_W],
                            m_tdata[VIDX_W+SAMPLE_W +: COUNT_W],
                            m_tdata[VIDX_W+SAMPLE_W+COUNT_W],
                            m_tdata[VIDX_W+SAMPLE_W+COUNT_W+1], m_tlast);
            gap = draw_gap();
            m_tready <= (gap == 0);
            rx_hold <= gap;
        end
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            if (rx_hold == 1)
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[sorted_site_overlap_sweep_core] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [CHROM_W-1:0] chrom,
                             logic [POS_W-1:0] beg, logic [POS_W-1:0] fin,
                             logic [POS_W-1:0] pos, logic [SAMPLE_W-1:0] sample);
        int unsigned gap;
        site_entry_t item;
        gap = draw_gap();
        item.chrom = chrom;
        item.span_start = beg;
        item.span_end = fin;
        item.position = pos;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, sample, pos, fin, beg, chrom};
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_item(op, item, sample);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned items_sent;
        int unsigned chrom_cursor;
        int unsigned base;
        int unsigned span;
        int unsigned off;
        int unsigned n_sites;
        int unsigned n_reads;
        int unsigned j;
        int unsigned k;
        logic [OP_W-1:0] noise_op;
        logic            dense;
        logic [POS_W-1:0] rbeg;
        logic [POS_W-1:0] rfin;
        site_entry_t     s;
        site_entry_t     sites [$];

        items_sent = 0;
        chrom_cursor = 10;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_item(OP_READ, '0, '0, POS_MAX, '0, 16'hFFFF);
        send_item(OP_IGNORED, CHROM_MAX, POS_MAX, POS_MAX, POS_MAX, 16'hFFFF);
        send_item(OP_RESTART, '0, '0, '0, '0, '0);
        send_item(OP_LOAD, 16'd0, 31'd0, 31'd0, 31'd0, 16'h00FF);
        send_item(OP_LOAD, 16'd0, 31'd5, 31'd20, 31'd10, 16'd0);
        send_item(OP_LOAD, 16'd0, 31'd8, 31'd30, 31'd40, 16'd0);
        send_item(OP_LOAD, 16'd3, 31'd100, 31'd200, 31'd150, 16'd0);
        send_item(OP_LOAD, 16'd3, 31'd150, 31'd160, 31'd155, 16'd0);
        send_item(OP_LOAD, CHROM_MAX, 31'h7FFF_FFF0, POS_MAX, POS_MAX, 16'hFF00);
        // Out of order on purpose: never passes the pointer, and is dead behind the last hit.
        send_item(OP_LOAD, 16'd2, 31'd1, 31'd1000, 31'd500, 16'd0);
        send_item(OP_READ, 16'd0, 31'd0, 31'd0, POS_MAX, 16'd1);
        send_item(OP_READ, 16'd0, 31'd9, 31'd45, 31'd0, 16'h8000);
        send_item(OP_READ, 16'd3, 31'd1, 31'd99, 31'd0, 16'h0001);
        send_item(OP_READ, 16'd3, 31'd150, 31'd155, 31'd0, 16'h7FFF);
        send_item(OP_READ, CHROM_MAX, POS_MAX, POS_MAX, 31'd0, 16'h5555);
        send_item(OP_READ, 16'd2, 31'd0, 31'd2000, 31'd0, 16'hAAAA);
        send_item(OP_RESTART, 16'hAAAA, 31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA, 16'h5555);
        send_item(OP_READ, 16'd2, 31'd0, 31'd2000, 31'd0, 16'h1234);
        wait_drained();

        while (items_sent < RANDOM_ITEMS)
        begin
            dense = ($urandom_range(0, 4) == 0);
            burst_mode <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0)
                wait_drained();
            send_item(OP_RESTART, 16'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
                      16'($urandom));
            items_sent++;
            sites.delete();
            chrom_cursor = chrom_cursor + $urandom_range(1, 3000);
            if (chrom_cursor > 65500)
                chrom_cursor = 65500;
            base = $urandom_range(0, 32'h7FF0_0000);
            n_sites = dense ? $urandom_range(62, 70) : $urandom_range(3, 14);
            s.chrom = CHROM_W'(chrom_cursor);
            for (k = 0; k < n_sites; k++)
            begin
                if (!dense && $urandom_range(0, 5) == 0)
                begin
                    chrom_cursor++;
                    s.chrom = CHROM_W'(chrom_cursor);
                    base = $urandom_range(0, 32'h7FF0_0000);
                end
                base = base + (dense ? $urandom_range(0, 3) : $urandom_range(0, 40));
                span = $urandom_range(0, 60);
                s.span_start = POS_W'(base);
                s.span_end = POS_W'(base + span);
                s.position = POS_W'(base + $urandom_range(0, dense ? span : span + 10));
                sites.insert(sites.size(), s);
                send_item(OP_LOAD, s.chrom, s.span_start, s.span_end, s.position,
                          16'($urandom));
                items_sent++;
            end
            n_reads = $urandom_range(3, 10);
            j = 0;
            for (k = 0; k < n_reads; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    noise_op = OP_W'($urandom_range(1, 3));
                    send_item(noise_op, 16'($urandom), 31'($urandom), 31'($urandom),
                              31'($urandom), 16'($urandom));
                    if (noise_op != OP_IGNORED)
                        items_sent++;
                end
                else
                begin
                    j = j + $urandom_range(0, 3);
                    if (j >= sites.size())
                        j = sites.size() - 1;
                    off = $urandom_range(0, 20);
                    rbeg = (sites[j].span_start > off) ? POS_W'(sites[j].span_start - off) : '0;
                    rfin = POS_W'(rbeg + $urandom_range(0, dense ? 200 : 120));
                    if (dense && k == 0)
                    begin
                        rbeg = sites[0].span_start;
                        rfin = sites[sites.size()-1].span_end;
                    end
                    send_item(OP_READ, sites[j].chrom, rbeg, rfin, 31'($urandom),
                              16'($urandom));
                    items_sent++;
                end
            end
        end

        // Sweep the whole table from the start, then probe the topmost positions.
        wait_drained();
        burst_mode <= 1'b0;
        send_item(OP_RESTART, '0, '0, '0, '0, '0);
        send_item(OP_READ, CHROM_MAX, '0, POS_MAX, '0, 16'hC3C3);
        send_item(OP_READ, CHROM_MAX, POS_MAX, POS_MAX, '0, 16'h3C3C);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[sorted_site_overlap_sweep_core] OK");
        else
            $display("[sorted_site_overlap_sweep_core] ERROR");
        $finish;
    end

endmodule
